// ===== rtl/core/rhc_pkg.sv =====
// Shared widths, scale factors and helper functions for the RGB to HSV converter.
// Used by rgb_to_hsv_converter and rhc_divider; depends on nothing else.
package rhc_pkg;

  localparam int CHAN_W    = 8;
  localparam int HNUM_W    = 11;
  localparam int HUE_W     = 16;
  localparam int SAT_W     = 14;
  localparam int BRIGHT_W  = 7;

  // The long divider works on an 8-bit divisor and produces a 16-bit quotient.
  localparam int DIVISOR_W   = CHAN_W;
  localparam int QUOT_W      = 16;
  localparam int DIVIDEND_W  = DIVISOR_W + QUOT_W;
  localparam int DIV_STAGES  = 4;
  localparam int DIV_STEPS   = QUOT_W / DIV_STAGES;

  localparam int HueScale    = 6000;
  localparam int SatScale    = 10000;
  localparam int BrightMul   = 40;
  localparam int BrightBias  = 51;
  // Division by 102 as a multiply by ceil(2^20 / 102) and a shift of 20.
  localparam int BrightRecip = 10281;
  localparam int BrightShift = 20;

  // Rounded percent of full scale: round(100 * mx / 255) = (40 * mx + 51) / 102.
  // The reciprocal product is exact for every scaled value up to 40 * 255 + 51.
  function automatic logic [BRIGHT_W-1:0] brightness_of(input logic [CHAN_W-1:0] mx);
    logic [13:0] scaled;
    logic [27:0] prod;
    scaled = 14'(BrightMul) * 14'(mx) + 14'(BrightBias);
    prod   = 28'(scaled) * 28'(BrightRecip);
    return BRIGHT_W'(prod >> BrightShift);
  endfunction

endpackage

// ===== rtl/core/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter: channel selection, scaling and pipeline control.
// Depends on rhc_pkg and rhc_divider (two instances, hue and saturation).
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   input   | in        | in_valid / in_ready   | red, green, blue
//   output  | out       | out_valid / out_ready | hue, saturation, brightness
//
// Six register stages: max/min and sector numerator, scaling multiplies, then
// four divider stages of four quotient bits each. One transaction is taken per
// cycle while the output is not stalled. Each stage holds its own valid bit and
// accepts new data whenever it is empty, so bubbles close up under a stall and
// in_ready drops only when every stage is full. Reset clears the valid bits.
module rgb_to_hsv_converter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rhc_pkg::CHAN_W-1:0]    red,
  input  logic [rhc_pkg::CHAN_W-1:0]    green,
  input  logic [rhc_pkg::CHAN_W-1:0]    blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rhc_pkg::HUE_W-1:0]     hue,
  output logic [rhc_pkg::SAT_W-1:0]     saturation,
  output logic [rhc_pkg::BRIGHT_W-1:0]  brightness
);
  import rhc_pkg::*;

  localparam int NumStages = 2 + DIV_STAGES;

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] en;

  // Stage loads when empty or when its content moves on.
  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: extremes, range and the hue sector numerator.
  logic [CHAN_W-1:0]   mx_c;
  logic [CHAN_W-1:0]   mn_c;
  logic [CHAN_W-1:0]   d_c;
  logic [HNUM_W-1:0]   hnum_c;

  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c)  mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c)  mn_c = blue;
    d_c = mx_c - mn_c;
    // Blue wins ties over green, green over red; every tie gives the same hue.
    if (mx_c == blue) begin
      hnum_c = HNUM_W'(red) + HNUM_W'({d_c, 2'b00}) - HNUM_W'(green);
    end else if (mx_c == green) begin
      hnum_c = HNUM_W'(blue) + HNUM_W'({d_c, 1'b0}) - HNUM_W'(red);
    end else if (green >= blue) begin
      hnum_c = HNUM_W'(green) - HNUM_W'(blue);
    end else begin
      hnum_c = HNUM_W'({d_c, 2'b00}) + HNUM_W'({d_c, 1'b0}) + HNUM_W'(green)
               - HNUM_W'(blue);
    end
  end

  logic [CHAN_W-1:0]   s1_mx;
  logic [CHAN_W-1:0]   s1_d;
  logic [HNUM_W-1:0]   s1_hnum;
  logic [BRIGHT_W-1:0] s1_bright;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_mx     <= mx_c;
      s1_d      <= d_c;
      s1_hnum   <= hnum_c;
      s1_bright <= brightness_of(mx_c);
    end
  end

  // Stage 2: scale numerators so the quotients come out in hundredths.
  logic [DIVIDEND_W-1:0] s2_hue_num;
  logic [DIVIDEND_W-1:0] s2_sat_num;
  logic [CHAN_W-1:0]     s2_d;
  logic [CHAN_W-1:0]     s2_mx;

  logic [BRIGHT_W-1:0] bright_pipe [NumStages-1];
  logic                grey_pipe   [NumStages-1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_hue_num     <= DIVIDEND_W'(s1_hnum) * DIVIDEND_W'(HueScale);
      s2_sat_num     <= DIVIDEND_W'(s1_d) * DIVIDEND_W'(SatScale);
      s2_d           <= s1_d;
      s2_mx          <= s1_mx;
      bright_pipe[0] <= s1_bright;
      grey_pipe[0]   <= (s1_d == '0);
    end
  end

  for (genvar k = 1; k < NumStages - 1; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        bright_pipe[k] <= bright_pipe[k-1];
        grey_pipe[k]   <= grey_pipe[k-1];
      end
    end
  end

  // Stages 3 to 6: the two quotients.
  logic [QUOT_W-1:0] hue_q;
  logic [QUOT_W-1:0] sat_q;

  rhc_divider u_hue_div (
    .clk      (clk),
    .en       (en[NumStages-1:2]),
    .dividend (s2_hue_num),
    .divisor  (s2_d),
    .quotient (hue_q)
  );

  rhc_divider u_sat_div (
    .clk      (clk),
    .en       (en[NumStages-1:2]),
    .dividend (s2_sat_num),
    .divisor  (s2_mx),
    .quotient (sat_q)
  );

  // A grey pixel has a zero range; the divider output is meaningless then.
  assign hue        = grey_pipe[NumStages-2] ? '0 : hue_q;
  assign saturation = grey_pipe[NumStages-2] ? '0 : sat_q[SAT_W-1:0];
  assign brightness = bright_pipe[NumStages-2];

`ifndef ASSERT_OFF
  // Any nonzero range gives a saturation of at least 39, so zero means grey.
  a_grey_hue : assert property (@(posedge clk) disable iff (rst)
    out_valid && saturation == '0 |-> hue == '0)
    else $error("grey pixel gave nonzero hue");

  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue < HUE_W'(36000) && saturation <= SAT_W'(SatScale))
    else $error("hue or saturation out of range");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> vld == '1)
    else $error("input stalled while a pipeline stage was empty");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// ===== rtl/core/rhc_divider.sv =====
// Pipelined restoring divider: 24-bit dividend over an 8-bit divisor, 16-bit quotient.
// Depends on rhc_pkg; each stage resolves DIV_STEPS quotient bits.
module rhc_divider (
  input  logic                          clk,
  input  logic [rhc_pkg::DIV_STAGES-1:0] en,
  input  logic [rhc_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [rhc_pkg::DIVISOR_W-1:0]  divisor,
  output logic [rhc_pkg::QUOT_W-1:0]     quotient
);
  import rhc_pkg::*;

  // The caller guarantees the quotient fits in QUOT_W bits, so the top
  // DIVISOR_W dividend bits are already a valid partial remainder.
  logic [DIVISOR_W-1:0] rem [DIV_STAGES-1];
  logic [DIVISOR_W-1:0] dvs [DIV_STAGES-1];
  logic [QUOT_W-1:0]    sh  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIVISOR_W-1:0] rem_in;
    logic [DIVISOR_W-1:0] dvs_in;
    logic [QUOT_W-1:0]    sh_in;
    logic [DIVISOR_W-1:0] rem_next;
    logic [QUOT_W-1:0]    sh_next;
    logic [DIVISOR_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in = dividend[DIVIDEND_W-1:QUOT_W];
      assign sh_in  = dividend[QUOT_W-1:0];
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign sh_in  = sh[k-1];
      assign dvs_in = dvs[k-1];
    end

    // Dividend bits leave the top of sh while quotient bits enter at the bottom.
    always_comb begin
      rem_next = rem_in;
      sh_next  = sh_in;
      trial    = '0;
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial   = {rem_next, sh_next[QUOT_W-1]};
        sh_next = {sh_next[QUOT_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs_in}) begin
          rem_next   = DIVISOR_W'(trial - {1'b0, dvs_in});
          sh_next[0] = 1'b1;
        end else begin
          rem_next = trial[DIVISOR_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        sh[k] <= sh_next;
      end
    end

    if (k < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= rem_next;
          dvs[k] <= dvs_in;
        end
      end
    end
  end

  assign quotient = sh[DIV_STAGES-1];

endmodule
